// File: src/lzw_code_decoder_top_assert.svh
// Assertion macros shared by the decoder RTL
`ifndef LZW_CODE_DECODER_TOP_ASSERT_SVH
`define LZW_CODE_DECODER_TOP_ASSERT_SVH

// implication checked every clock, off during reset
`define LZWD_ASSERT_IMP(label, clk, rst_n, a, c) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (c)) \
        else $error("lzwd check failed");

// next-cycle implication, off during reset
`define LZWD_ASSERT_NEXT(label, clk, rst_n, a, c) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (c)) \
        else $error("lzwd check failed");

`endif

// File: src/lzwd_pkg.sv
// ----------------------------------------------------------------------------
// lzwd_pkg
// Types and constants shared by the LZW code decoder.
// ----------------------------------------------------------------------------
package lzwd_pkg;

    localparam int CODE_WIDTH = 12;
    localparam int MAX_RUN    = 64;
    localparam int DICT_DEPTH = 1 << CODE_WIDTH;
    localparam int CNT_W      = CODE_WIDTH + 1;
    localparam int RUN_W      = $clog2(MAX_RUN + 1);
    localparam logic [CODE_WIDTH-1:0] LITERALS = CODE_WIDTH'(256);

    localparam logic [1:0] OP_FIRST = 2'd0;
    localparam logic [1:0] OP_NEXT  = 2'd1;
    localparam logic [1:0] OP_CONT  = 2'd2;

    localparam logic [1:0] REG_INIT_SIZE = 2'd0;
    localparam logic [1:0] REG_MAX_WIDTH = 2'd1;

    typedef struct packed {
        logic [1:0]            opcode;
        logic [CODE_WIDTH-1:0] code_in;
    } in_item_t;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       run_last;
        logic       more_pending;
        logic       bad_start;
    } out_item_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_DECODE,
        ST_WALK_RD,
        ST_WALK_WAIT,
        ST_WALK_USE,
        ST_INSERT,
        ST_POP_RD,
        ST_POP_WAIT,
        ST_EMIT,
        ST_BAD
    } state_t;

    // controller -> datapath
    typedef struct packed {
        logic load_item;   // capture input item
        logic decode;      // classify code, set walk start
        logic walk_rd;     // issue table read at walk pointer
        logic walk_use;    // push suffix, follow prefix
        logic insert;      // write new entry, update prev
        logic pop_rd;      // issue stack read
        logic emit;        // present byte on output
        logic bad;         // present bad start item
        logic out_take;    // output register consumed
    } cmd_t;

    // datapath -> controller
    typedef struct packed {
        logic [1:0] opcode;
        logic       first_bad;
        logic       walk_done;
        logic       stack_empty;
        logic       run_full;
        logic       out_full;
    } status_t;

endpackage

// File: src/lzwd_ram.sv
// ----------------------------------------------------------------------------
// lzwd_ram
// Single-port-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module lzwd_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4096
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule

// File: src/lzwd_ctrl.sv
// ----------------------------------------------------------------------------
// lzwd_ctrl
// Sequencer: decode, prefix walk, dictionary insert, pop and emit.
// ----------------------------------------------------------------------------
`include "lzw_code_decoder_top_assert.svh"

module lzwd_ctrl (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    output logic             in_stall,
    input  logic             out_stall,
    input  lzwd_pkg::status_t sts,
    output lzwd_pkg::cmd_t   cmd
);
    import lzwd_pkg::*;

    state_t state_reg, state_next;
    logic   accept;

    assign accept = in_valid && (state_reg == ST_IDLE);
    assign in_stall = (state_reg != ST_IDLE);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:      if (accept) state_next = ST_DECODE;
            ST_DECODE:
            begin
                case (sts.opcode)
                    OP_FIRST: state_next = sts.first_bad ? ST_BAD : ST_POP_RD;
                    OP_NEXT:  state_next = ST_WALK_RD;
                    OP_CONT:  state_next = ST_POP_RD;
                    default:  state_next = ST_IDLE;
                endcase
            end
            ST_WALK_RD:   state_next = sts.walk_done ? ST_INSERT : ST_WALK_WAIT;
            ST_WALK_WAIT: state_next = ST_WALK_USE;
            ST_WALK_USE:  state_next = ST_WALK_RD;
            ST_INSERT:    state_next = ST_POP_RD;
            ST_POP_RD:
            begin
                if (sts.stack_empty || sts.run_full)
                begin
                    state_next = ST_IDLE;
                end
                else if (!sts.out_full || !out_stall)
                begin
                    state_next = ST_POP_WAIT;
                end
            end
            ST_POP_WAIT:  state_next = ST_EMIT;
            ST_EMIT:      state_next = ST_POP_RD;
            ST_BAD:       if (!sts.out_full || !out_stall) state_next = ST_IDLE;
            default:      state_next = ST_IDLE;
        endcase
    end

    always_comb
    begin
        cmd = '0;
        cmd.out_take = sts.out_full && !out_stall;
        case (state_reg)
            ST_IDLE:     cmd.load_item = accept;
            ST_DECODE:   cmd.decode = 1'b1;
            ST_WALK_RD:  cmd.walk_rd = !sts.walk_done;
            ST_WALK_USE: cmd.walk_use = 1'b1;
            ST_INSERT:   cmd.insert = 1'b1;
            ST_POP_RD:   cmd.pop_rd = !sts.stack_empty && !sts.run_full
                                      && (!sts.out_full || !out_stall);
            ST_EMIT:     cmd.emit = 1'b1;
            ST_BAD:      cmd.bad = !sts.out_full || !out_stall;
            default:     cmd = '0;
        endcase
    end

    `LZWD_ASSERT_IMP(a_emit_room, clk, rst_n, cmd.emit, !sts.out_full || !out_stall)
    `LZWD_ASSERT_NEXT(a_load_decode, clk, rst_n, cmd.load_item, state_reg == ST_DECODE)
    `LZWD_ASSERT_IMP(a_walk_no_out, clk, rst_n, state_reg == ST_WALK_USE, !in_stall == 1'b0)

endmodule

// File: src/lzwd_datapath.sv
// ----------------------------------------------------------------------------
// lzwd_datapath
// Dictionary tables, byte stack, prev state and output register.
// ----------------------------------------------------------------------------
`include "lzw_code_decoder_top_assert.svh"

module lzwd_datapath (
    input  logic                 clk,
    input  logic                 rst_n,
    input  lzwd_pkg::in_item_t   in_item,
    input  logic                 cfg_we,
    input  logic [1:0]           cfg_index,
    input  logic [11:0]          cfg_data,
    input  lzwd_pkg::cmd_t       cmd,
    output lzwd_pkg::status_t    sts,
    output logic                 out_valid,
    output lzwd_pkg::out_item_t  out_item
);
    import lzwd_pkg::*;

    localparam int AW = CODE_WIDTH;

    logic [11:0]       init_size_reg;
    logic [3:0]        max_width_reg;
    in_item_t          item_reg;
    logic [CNT_W-1:0]  next_index_reg;
    logic [AW-1:0]     prev_code_reg;
    logic [7:0]        prev_fb_reg;
    logic [CNT_W-1:0]  stack_cnt_reg;
    logic [AW-1:0]     walk_reg;
    logic              walk_fin_reg;
    logic [7:0]        f_reg;
    logic              unknown_reg;
    logic [RUN_W-1:0]  run_cnt_reg;
    logic              out_valid_reg;
    out_item_t         out_reg;

    logic [AW-1:0] prefix_rd;
    logic [7:0]    suffix_rd, fb_rd, stack_rd;
    logic [AW-1:0] tbl_raddr;
    logic          stack_we;
    logic [AW-1:0] stack_waddr;
    logic [7:0]    stack_wdata;
    logic [AW-1:0] stack_raddr;
    logic [CNT_W-1:0] ins_idx;
    logic [CNT_W-1:0] limit;
    logic [3:0]    width_eff;
    logic          stack_full;
    logic [AW-1:0] code;
    logic          known;

    assign code = item_reg.code_in;
    assign known = ({1'b0, code} >= CNT_W'(init_size_reg)) && ({1'b0, code} < next_index_reg);
    assign stack_full = stack_cnt_reg[CNT_W-1];
    assign width_eff = (max_width_reg > 4'(CODE_WIDTH)) ? 4'(CODE_WIDTH) : max_width_reg;
    assign limit = CNT_W'(1) << width_eff;
    assign ins_idx = (next_index_reg >= limit) ? CNT_W'(init_size_reg) : next_index_reg;
    assign tbl_raddr = (cmd.decode) ? code : walk_reg;
    // popped byte sits at the decremented count; read in the wait cycle
    assign stack_raddr = stack_cnt_reg[AW-1:0];

    always_comb
    begin
        stack_we = 1'b0;
        stack_wdata = '0;
        if (cmd.decode && item_reg.opcode == OP_FIRST)
        begin
            stack_we = 1'b1;
            stack_wdata = code[7:0];
        end
        else if (cmd.decode && item_reg.opcode == OP_NEXT && (code < LITERALS || !known))
        begin
            stack_we = 1'b1;
            stack_wdata = (code < LITERALS) ? code[7:0] : prev_fb_reg;
        end
        else if (cmd.walk_use && !stack_full && !walk_fin_reg)
        begin
            stack_we = 1'b1;
            stack_wdata = suffix_rd;
        end
        else if (cmd.walk_rd && walk_reg < LITERALS && !stack_full)
        begin
            stack_we = 1'b1;
            stack_wdata = walk_reg[7:0];
        end
    end
    assign stack_waddr = cmd.decode ? '0 : stack_cnt_reg[AW-1:0];

    lzwd_ram #(.WIDTH(AW), .DEPTH(DICT_DEPTH)) u_prefix (
        .clk(clk), .we(cmd.insert), .waddr(ins_idx[AW-1:0]), .wdata(prev_code_reg),
        .raddr(tbl_raddr), .rdata(prefix_rd));
    lzwd_ram #(.WIDTH(8), .DEPTH(DICT_DEPTH)) u_suffix (
        .clk(clk), .we(cmd.insert), .waddr(ins_idx[AW-1:0]), .wdata(f_reg),
        .raddr(tbl_raddr), .rdata(suffix_rd));
    lzwd_ram #(.WIDTH(8), .DEPTH(DICT_DEPTH)) u_first (
        .clk(clk), .we(cmd.insert), .waddr(ins_idx[AW-1:0]), .wdata(prev_fb_reg),
        .raddr(tbl_raddr), .rdata(fb_rd));
    lzwd_ram #(.WIDTH(8), .DEPTH(DICT_DEPTH)) u_stack (
        .clk(clk), .we(stack_we), .waddr(stack_waddr), .wdata(stack_wdata),
        .raddr(stack_raddr), .rdata(stack_rd));

    // walk_done: either the literal end was pushed or stack ran full
    assign sts.opcode = item_reg.opcode;
    assign sts.first_bad = (code >= LITERALS);
    assign sts.walk_done = walk_fin_reg || stack_full;
    assign sts.stack_empty = (stack_cnt_reg == '0);
    assign sts.run_full = (run_cnt_reg == RUN_W'(MAX_RUN));
    assign sts.out_full = out_valid_reg;

    always_ff @(posedge clk)
    begin
        if (cmd.load_item)
        begin
            item_reg <= in_item;
        end
        if (cmd.decode)
        begin
            unknown_reg <= (code >= LITERALS) && !known;
            walk_fin_reg <= (code < LITERALS);
            walk_reg <= (code < LITERALS) ? LITERALS : (known ? code : prev_code_reg);
            f_reg <= (code < LITERALS) ? code[7:0] : (known ? 8'h00 : prev_fb_reg);
        end
        else if (cmd.walk_use && !walk_fin_reg)
        begin
            walk_reg <= prefix_rd;
        end
        else if (cmd.walk_rd && walk_reg < LITERALS)
        begin
            walk_fin_reg <= 1'b1;
        end
        // first byte of a known code arrives with the first walk read
        if (cmd.walk_use && !unknown_reg && walk_reg == code && f_reg == 8'h00
            && code >= LITERALS)
        begin
            f_reg <= fb_rd;
        end
        if (cmd.emit || cmd.bad)
        begin
            out_reg.out_byte <= cmd.bad ? 8'h00 : stack_rd;
            out_reg.bad_start <= cmd.bad;
            out_reg.run_last <= cmd.bad || (stack_cnt_reg == '0)
                                || (run_cnt_reg == RUN_W'(MAX_RUN));
            // bytes left once this run ends
            out_reg.more_pending <= !cmd.bad
                && ((stack_cnt_reg + CNT_W'(run_cnt_reg)) > CNT_W'(MAX_RUN));
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            init_size_reg  <= 12'd256;
            max_width_reg  <= 4'd12;
            next_index_reg <= CNT_W'(256);
            prev_code_reg  <= '0;
            prev_fb_reg    <= '0;
            stack_cnt_reg  <= '0;
            run_cnt_reg    <= '0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            if (cfg_we && cfg_index == REG_INIT_SIZE)
            begin
                init_size_reg <= cfg_data;
            end
            if (cfg_we && cfg_index == REG_MAX_WIDTH)
            begin
                max_width_reg <= cfg_data[3:0];
            end
            if (cmd.load_item)
            begin
                run_cnt_reg <= '0;
            end
            if (cmd.decode)
            begin
                case (item_reg.opcode)
                    OP_FIRST:
                    begin
                        next_index_reg <= CNT_W'(init_size_reg);
                        prev_code_reg  <= (code < LITERALS) ? code : '0;
                        prev_fb_reg    <= (code < LITERALS) ? code[7:0] : 8'h00;
                        stack_cnt_reg  <= (code < LITERALS) ? CNT_W'(1) : '0;
                    end
                    OP_NEXT:
                    begin
                        stack_cnt_reg <= (code < LITERALS || !known) ? CNT_W'(1) : '0;
                    end
                    default:
                    begin
                        stack_cnt_reg <= stack_cnt_reg;
                    end
                endcase
            end
            else if (stack_we)
            begin
                stack_cnt_reg <= stack_cnt_reg + CNT_W'(1);
            end
            else if (cmd.pop_rd)
            begin
                stack_cnt_reg <= stack_cnt_reg - CNT_W'(1);
                run_cnt_reg <= run_cnt_reg + RUN_W'(1);
            end
            if (cmd.insert)
            begin
                next_index_reg <= ins_idx + CNT_W'(1);
                prev_code_reg  <= unknown_reg ? ins_idx[AW-1:0] : code;
                prev_fb_reg    <= f_reg;
            end
            if (cmd.emit || cmd.bad)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (cmd.out_take)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    assign out_valid = out_valid_reg;
    assign out_item = out_reg;

    `LZWD_ASSERT_IMP(a_stack_bound, clk, rst_n, 1'b1, stack_cnt_reg <= CNT_W'(DICT_DEPTH))
    `LZWD_ASSERT_IMP(a_run_bound, clk, rst_n, 1'b1, run_cnt_reg <= RUN_W'(MAX_RUN))
    `LZWD_ASSERT_NEXT(a_ins_next, clk, rst_n, cmd.insert, next_index_reg != '0)

endmodule

// File: src/lzw_code_decoder_top.sv
// ----------------------------------------------------------------------------
// lzw_code_decoder_top
// LZW decoder: one code in, its string out one byte per item.
// ----------------------------------------------------------------------------
// An item is taken only while the block is idle, one at a time. The
// accepted item is captured and then decoded. A next code then walks its
// prefix chain, each string byte taking a read, a wait and a use step (one
// registered dictionary read each), a literal code leaving the walk at once,
// and then writes the new entry. Every byte emitted takes a stack read, a
// wait and an output load, and a final pop-read check closes the run; output
// stalls hold the stack read and the bad start item. Runs stop at 64 bytes
// with more_pending set when bytes remain; a continue item drains the rest.
module lzw_code_decoder_top (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_stall,
    input  lzwd_pkg::in_item_t  in_data,
    output logic                out_valid,
    input  logic                out_stall,
    output lzwd_pkg::out_item_t out_data,
    input  logic                cfg_we,
    input  logic [1:0]          cfg_index,
    input  logic [11:0]         cfg_data
);
    import lzwd_pkg::*;

    cmd_t    cmd;
    status_t sts;

    lzwd_ctrl u_ctrl (
        .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_stall(in_stall),
        .out_stall(out_stall), .sts(sts), .cmd(cmd));

    lzwd_datapath u_dp (
        .clk(clk), .rst_n(rst_n), .in_item(in_data), .cfg_we(cfg_we),
        .cfg_index(cfg_index), .cfg_data(cfg_data), .cmd(cmd), .sts(sts),
        .out_valid(out_valid), .out_item(out_data));
endmodule

// File: test/testbench.sv
// ----------------------------------------------------------------------------
// LZW code decoder testbench
// Directed codes run first, then one string grown past a full run, then
// random streams in several dictionary settings, most with both sides
// idling at random. Each decoded byte is checked by field against a model.
// ----------------------------------------------------------------------------
module testbench;
    import lzwd_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int STACK_DEPTH = 4096;
    localparam int QUIET_LIMIT = 60000;

    logic      clk;
    logic      rst_n;
    logic      in_valid;
    logic      in_stall;
    in_item_t  in_data;
    logic      out_valid;
    logic      out_stall = 1'b0;
    out_item_t out_data;
    logic      cfg_we;
    logic [1:0]  cfg_index;
    logic [11:0] cfg_data;

    lzw_code_decoder_top u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // decoder model state
    logic [11:0] dict_prefix [STACK_DEPTH];
    logic [7:0]  dict_suffix [STACK_DEPTH];
    logic [7:0]  dict_first  [STACK_DEPTH];
    logic [7:0]  byte_stack  [STACK_DEPTH];
    int unsigned stack_len;
    int unsigned next_code;
    logic [11:0] last_code;
    logic [7:0]  last_first;
    int unsigned dict_base;
    int unsigned width_reg;

    out_item_t   pending_bytes [$];
    int          fail_count;
    int          items_sent;
    int          bytes_checked;
    int          split_runs;
    int          bad_starts;
    int          quiet_cycles;
    bit          no_idle;
    bit          hold_req;
    bit          hold_done;
    int          hold_left;

    typedef struct {
        logic [1:0]  op;
        logic [11:0] code;
        bit          typed;
        logic [7:0]  exp_byte;
        bit          exp_bad;
    } dir_row_t;

    always
    begin
        clk = 1'b1;
        #1;
        clk = 1'b0;
        #1;
    end

    task automatic report_mismatch(input string msg);
        begin
            fail_count++;
            $display("MISMATCH @%0t: %s", $realtime, msg);
        end
    endtask

    function automatic void push_byte(input logic [7:0] b);
        if (stack_len < STACK_DEPTH)
        begin
            byte_stack[stack_len] = b;
            stack_len++;
        end
    endfunction

    function automatic void walk_string(input logic [11:0] c);
        while (c >= 12'd256 && stack_len < STACK_DEPTH)
        begin
            push_byte(dict_suffix[c]);
            c = dict_prefix[c];
        end
        if (c < 12'd256)
            push_byte(c[7:0]);
    endfunction

    function automatic void emit_bytes();
        logic [7:0] run [$];
        bit more;
        out_item_t o;
        while (stack_len > 0 && run.size() < MAX_RUN)
        begin
            stack_len--;
            run.push_back(byte_stack[stack_len]);
        end
        more = (stack_len > 0);
        if (more)
            split_runs++;
        foreach (run[k])
        begin
            o.out_byte     = run[k];
            o.run_last     = (k == run.size() - 1);
            o.more_pending = more;
            o.bad_start    = 1'b0;
            pending_bytes.push_back(o);
        end
    endfunction

    // expected bytes for one accepted item
    function automatic void decode_code(input in_item_t it);
        int unsigned lim;
        int unsigned slot;
        logic [7:0] fb;
        bit unknown;
        out_item_t o;
        unknown = 1'b0;
        if (it.opcode == OP_FIRST)
        begin
            stack_len = 0;
            next_code = dict_base;
            if (it.code_in >= 12'd256)
            begin
                last_code  = '0;
                last_first = '0;
                o = '{out_byte: 8'h00, run_last: 1'b1, more_pending: 1'b0, bad_start: 1'b1};
                pending_bytes.push_back(o);
                bad_starts++;
                return;
            end
            last_code  = it.code_in;
            last_first = it.code_in[7:0];
            push_byte(it.code_in[7:0]);
            emit_bytes();
            return;
        end
        if (it.opcode == OP_CONT)
        begin
            emit_bytes();
            return;
        end
        if (it.opcode != OP_NEXT)
            return;
        stack_len = 0;
        if (it.code_in < 12'd256)
        begin
            fb = it.code_in[7:0];
            push_byte(fb);
        end
        else if (it.code_in >= dict_base && it.code_in < next_code)
        begin
            fb = dict_first[it.code_in];
            walk_string(it.code_in);
        end
        else
        begin
            // KwKwK case: previous string plus its own first byte
            unknown = 1'b1;
            fb = last_first;
            push_byte(fb);
            walk_string(last_code);
        end
        lim = 1 << ((width_reg > CODE_WIDTH) ? CODE_WIDTH : width_reg);
        if (next_code >= lim)
            next_code = dict_base;
        slot = next_code % STACK_DEPTH;
        dict_prefix[slot] = last_code;
        dict_suffix[slot] = fb;
        dict_first[slot]  = last_first;
        next_code = next_code + 1;
        last_code  = unknown ? slot[11:0] : it.code_in;
        last_first = fb;
        emit_bytes();
    endfunction

    task automatic send_item(input logic [1:0] op, input logic [11:0] code, input bit typed,
                             input logic [7:0] exp_byte, input bit exp_bad);
        in_item_t it;
        int before_len;
        out_item_t o;
        begin
            it.opcode  = op;
            it.code_in = code;
            if (!no_idle && $urandom_range(0, 99) < 14)
            begin
                in_valid <= 1'b0;
                repeat ($urandom_range(1, 4)) @(posedge clk);
            end
            in_valid <= 1'b1;
            in_data  <= it;
            do @(negedge clk); while (in_stall);
            @(posedge clk);
            items_sent++;
            before_len = pending_bytes.size();
            decode_code(it);
            if (typed)
            begin
                while (pending_bytes.size() > before_len)
                    void'(pending_bytes.pop_back());
                o = '{out_byte: exp_byte, run_last: 1'b1, more_pending: 1'b0,
                      bad_start: exp_bad};
                pending_bytes.push_back(o);
            end
        end
    endtask

    task automatic drain_all();
        begin
            in_valid <= 1'b0;
            @(posedge clk);
            while (pending_bytes.size() != 0)
                @(posedge clk);
            // items with no result may still be in flight
            repeat (40) @(posedge clk);
        end
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [11:0] val);
        begin
            cfg_we    <= 1'b1;
            cfg_index <= idx;
            cfg_data  <= val;
            @(posedge clk);
            cfg_we    <= 1'b0;
            @(posedge clk);
            if (idx == REG_INIT_SIZE)
                dict_base = val;
            else if (idx == REG_MAX_WIDTH)
                width_reg = val[3:0];
        end
    endtask

    function automatic logic [11:0] grow_code();
        return (next_code < STACK_DEPTH) ? next_code[11:0] : 12'hFFF;
    endfunction

    task automatic random_stream(input int count);
        int r;
        int s;
        logic [11:0] c;
        begin
            send_item(OP_FIRST, 12'($urandom_range(0, 255)), 1'b0, 8'h00, 1'b0);
            repeat (count)
            begin
                r = $urandom_range(0, 99);
                if (r < 4)
                begin
                    c = ($urandom_range(0, 9) == 0) ? 12'($urandom_range(256, 4095))
                                                    : 12'($urandom_range(0, 255));
                    send_item(OP_FIRST, c, 1'b0, 8'h00, 1'b0);
                end
                else if (r < 12)
                    send_item(OP_CONT, 12'($urandom), 1'b0, 8'h00, 1'b0);
                else if (r < 15)
                    send_item(2'd3, 12'($urandom), 1'b0, 8'h00, 1'b0);
                else
                begin
                    s = $urandom_range(0, 99);
                    if (s < 45 && next_code > dict_base && next_code <= STACK_DEPTH)
                        c = 12'($urandom_range(dict_base, next_code - 1));
                    else if (s < 70)
                        c = 12'($urandom_range(0, 255));
                    else if (s < 85)
                        c = grow_code();
                    else
                        c = 12'($urandom);
                    send_item(OP_NEXT, c, 1'b0, 8'h00, 1'b0);
                end
            end
        end
    endtask

    // receiver: random stall, one long hold on request
    always @(posedge clk)
    begin
        if (hold_left > 0)
        begin
            hold_left  <= hold_left - 1;
            out_stall  <= 1'b1;
        end
        else if (hold_req && !hold_done)
        begin
            hold_done  <= 1'b1;
            hold_left  <= 400;
            out_stall  <= 1'b1;
        end
        else
            out_stall <= !no_idle && ($urandom_range(0, 99) < 14);
    end

    always @(posedge clk)
    begin
        out_item_t exp_o;
        if (rst_n && out_valid && !out_stall)
        begin
            bytes_checked++;
            if (pending_bytes.size() == 0)
                report_mismatch($sformatf("unexpected item %p", out_data));
            else
            begin
                exp_o = pending_bytes.pop_front();
                if (out_data.out_byte !== exp_o.out_byte)
                    report_mismatch($sformatf("out_byte %h, want %h",
                                              out_data.out_byte, exp_o.out_byte));
                if (out_data.run_last !== exp_o.run_last)
                    report_mismatch($sformatf("run_last %b, want %b",
                                              out_data.run_last, exp_o.run_last));
                if (out_data.more_pending !== exp_o.more_pending)
                    report_mismatch($sformatf("more_pending %b, want %b",
                                              out_data.more_pending, exp_o.more_pending));
                if (out_data.bad_start !== exp_o.bad_start)
                    report_mismatch($sformatf("bad_start %b, want %b",
                                              out_data.bad_start, exp_o.bad_start));
            end
        end
    end

    // watchdog on cycles with no handshake on either side
    always @(posedge clk)
    begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall) || !rst_n)
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles > QUIET_LIMIT)
        begin
            $display("Simulation FAILED");
            $finish;
        end
    end

    initial
    begin
        dir_row_t dir_rows [$];
        dir_row_t row;
        in_valid  = 1'b0;
        in_data   = '0;
        cfg_we    = 1'b0;
        cfg_index = REG_INIT_SIZE;
        cfg_data  = '0;
        rst_n     = 1'b0;
        items_sent = 0;
        split_runs = 0;
        bad_starts = 0;
        no_idle   = 1'b0;
        hold_req  = 1'b0;
        stack_len = 0;
        dict_base = 256;
        width_reg = 12;
        next_code = 256;
        last_code = '0;
        last_first = '0;

        dir_rows = '{
            '{OP_NEXT,  12'h041, 1'b0, 8'h00, 1'b0},   // next code with no stream
            '{OP_FIRST, 12'h000, 1'b1, 8'h00, 1'b0},
            '{OP_NEXT,  12'h0FF, 1'b1, 8'hFF, 1'b0},
            '{OP_NEXT,  12'h100, 1'b0, 8'h00, 1'b0},
            '{OP_NEXT,  12'h12C, 1'b0, 8'h00, 1'b0},   // not yet in dictionary
            '{OP_NEXT,  12'h102, 1'b0, 8'h00, 1'b0},
            '{OP_NEXT,  12'hFFF, 1'b0, 8'h00, 1'b0},
            '{OP_CONT,  12'h000, 1'b0, 8'h00, 1'b0},   // nothing pending
            '{2'd3,     12'hFFF, 1'b0, 8'h00, 1'b0},   // ignored opcode
            '{OP_FIRST, 12'hFFF, 1'b1, 8'h00, 1'b1},
            '{OP_NEXT,  12'h055, 1'b0, 8'h00, 1'b0},
            '{OP_FIRST, 12'h100, 1'b1, 8'h00, 1'b1},
            '{OP_FIRST, 12'h0FF, 1'b1, 8'hFF, 1'b0},
            '{OP_NEXT,  12'h0AA, 1'b0, 8'h00, 1'b0},
            '{OP_NEXT,  12'h800, 1'b0, 8'h00, 1'b0},
            '{OP_NEXT,  12'h100, 1'b0, 8'h00, 1'b0},
            '{OP_FIRST, 12'h07F, 1'b1, 8'h7F, 1'b0},
            '{OP_CONT,  12'hABC, 1'b0, 8'h00, 1'b0}
        };

        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (dir_rows[i])
        begin
            row = dir_rows[i];
            send_item(row.op, row.code, row.typed, row.exp_byte, row.exp_bad);
        end

        // grow one string past a full run, with one long receiver hold at the start
        hold_req = 1'b1;
        send_item(OP_FIRST, 12'h061, 1'b0, 8'h00, 1'b0);
        repeat (80)
        begin
            send_item(OP_NEXT, grow_code(), 1'b0, 8'h00, 1'b0);
            if (stack_len > 0 && $urandom_range(0, 1) == 0)
                send_item(OP_CONT, 12'h000, 1'b0, 8'h00, 1'b0);
        end
        drain_all();

        write_reg(REG_INIT_SIZE, 12'hFFF);
        write_reg(REG_MAX_WIDTH, 12'd9);
        random_stream(20);
        drain_all();

        no_idle = 1'b1;
        write_reg(REG_INIT_SIZE, 12'd256);
        random_stream(20);
        drain_all();
        no_idle = 1'b0;

        write_reg(REG_INIT_SIZE, 12'd300);
        write_reg(REG_MAX_WIDTH, 12'd10);
        random_stream(20);
        drain_all();

        write_reg(REG_INIT_SIZE, 12'd1000);
        write_reg(REG_MAX_WIDTH, 12'd15);
        random_stream(20);
        drain_all();

        write_reg(REG_INIT_SIZE, 12'd256);
        write_reg(REG_MAX_WIDTH, 12'd12);
        random_stream(20);
        drain_all();

        $display("Sent %0d codes, checked %0d output bytes", items_sent, bytes_checked);
        $display("Runs split for continue: %0d, bad stream starts: %0d",
                 split_runs, bad_starts);
        if (fail_count == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule
